// File: design/brt_pkg.sv
// Package for the binary trie route table: shared constants, controller state,
// response kinds and the command and status bundles between controller and datapath.
// No dependencies.
package brt_pkg;

   localparam int ROUTES_DEF = 256;
   localparam int NODES_DEF  = 8192;
   localparam int ADDR_W     = 32;
   localparam int LEN_W      = 6;
   localparam logic [LEN_W-1:0] MAX_DEPTH = 6'd32;

   // Operation codes of a request item
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_CHECK,
      ST_COST,
      ST_ALLOC,
      ST_SET,
      ST_FETCH,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      RESP_FULL,
      RESP_ACCEPT,
      RESP_REJECT,
      RESP_LOOKUP
   } resp_kind_type;

   typedef struct packed {
      logic          start;
      logic          walk;
      logic          alloc;
      logic          set_route;
      logic          replace;
      logic          load_rsp;
      resp_kind_type kind;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_lookup;
      logic walk_done;
      logic found_now;
      logic full;
      logic at_end;
      logic has_route;
      logic alloc_last;
      logic cheaper;
      logic out_free;
   } dp_status_type;

endpackage

// File: design/brt_if.sv
// Handshake channels of the route table: request and response items.
// Depends on nothing.
interface brt_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [31:0] address;
   logic [5:0]  prefix_length;
   logic [31:0] next_hop;
   logic [31:0] route_metric;
   logic [7:0]  interface_index;

   modport source  (output valid, operation, address, prefix_length, next_hop,
                    route_metric, interface_index, input ready);
   modport sink    (input valid, operation, address, prefix_length, next_hop,
                    route_metric, interface_index, output ready);
   modport monitor (input valid, ready, operation, address, prefix_length, next_hop,
                    route_metric, interface_index);
endinterface

interface brt_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic        found;
   logic [31:0] out_next_hop;
   logic [31:0] out_metric;
   logic [7:0]  out_interface;
   logic        table_full;

   modport source  (output valid, accepted, found, out_next_hop, out_metric,
                    out_interface, table_full, input ready);
   modport sink    (input valid, accepted, found, out_next_hop, out_metric,
                    out_interface, table_full, output ready);
   modport monitor (input valid, ready, accepted, found, out_next_hop, out_metric,
                    out_interface, table_full);
endinterface

// File: design/brt_ctrl.sv
// Controller of the route table: sequences walk, pool check, metric compare, allocation,
// route write and response. Depends on brt_pkg.
module brt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   idle,
   input  brt_pkg::dp_status_type status,
   output brt_pkg::ctrl_cmd_type  cmd
);

   brt_pkg::state_type     state_ff, state_in;
   brt_pkg::resp_kind_type kind_ff, kind_in;

   // State and response kind registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brt_pkg::ST_IDLE;
         kind_ff  <= brt_pkg::RESP_REJECT;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      cmd.kind = kind_ff;
      idle     = 1'b0;
      unique case (state_ff)
         brt_pkg::ST_IDLE: begin
            idle      = 1'b1;
            cmd.start = req_valid;
            if (req_valid) state_in = brt_pkg::ST_WALK;
         end
         brt_pkg::ST_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_done) begin
               if (status.is_lookup) begin
                  kind_in  = brt_pkg::RESP_LOOKUP;
                  state_in = status.found_now ? brt_pkg::ST_FETCH : brt_pkg::ST_RESP;
               end else begin
                  state_in = brt_pkg::ST_CHECK;
               end
            end
         end
         brt_pkg::ST_CHECK: begin
            if (status.full) begin
               kind_in  = brt_pkg::RESP_FULL;
               state_in = brt_pkg::ST_RESP;
            end else if (status.at_end && status.has_route) begin
               state_in = brt_pkg::ST_COST;
            end else if (status.at_end) begin
               state_in = brt_pkg::ST_SET;
            end else begin
               state_in = brt_pkg::ST_ALLOC;
            end
         end
         brt_pkg::ST_COST: begin
            cmd.replace = status.cheaper;
            kind_in     = status.cheaper ? brt_pkg::RESP_ACCEPT : brt_pkg::RESP_REJECT;
            state_in    = brt_pkg::ST_RESP;
         end
         brt_pkg::ST_ALLOC: begin
            cmd.alloc = 1'b1;
            if (status.alloc_last) state_in = brt_pkg::ST_SET;
         end
         brt_pkg::ST_SET: begin
            cmd.set_route = 1'b1;
            kind_in       = brt_pkg::RESP_ACCEPT;
            state_in      = brt_pkg::ST_RESP;
         end
         brt_pkg::ST_FETCH: begin
            state_in = brt_pkg::ST_RESP;
         end
         brt_pkg::ST_RESP: begin
            if (status.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = brt_pkg::ST_IDLE;
            end
         end
         default: state_in = brt_pkg::ST_IDLE;
      endcase
   end

endmodule

// File: design/brt_dp.sv
// Datapath of the route table: node memory, route memories, pool counters,
// walk registers and the response register. Depends on brt_pkg.
module brt_dp #(
   parameter int ROUTES = brt_pkg::ROUTES_DEF,
   parameter int NODES  = brt_pkg::NODES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  brt_pkg::ctrl_cmd_type  cmd,
   output brt_pkg::dp_status_type status,
   input  logic                   in_operation,
   input  logic [31:0]            in_address,
   input  logic [5:0]             in_prefix_length,
   input  logic [31:0]            in_next_hop,
   input  logic [31:0]            in_route_metric,
   input  logic [7:0]             in_interface_index,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_accepted,
   output logic                   rsp_found,
   output logic [31:0]            rsp_out_next_hop,
   output logic [31:0]            rsp_out_metric,
   output logic [7:0]             rsp_out_interface,
   output logic                   rsp_table_full
);

   localparam int NODE_W = $clog2(NODES);
   localparam int ROUTE_W = $clog2(ROUTES);
   localparam int NC_W = $clog2(NODES + 1);
   localparam int RC_W = $clog2(ROUTES + 1);
   localparam int LW = brt_pkg::LEN_W;

   typedef struct packed {
      logic [NODE_W-1:0]  left;
      logic [NODE_W-1:0]  right;
      logic               has_route;
      logic [ROUTE_W-1:0] route;
   } entry_type;

   entry_type          node_mem [NODES];
   logic [31:0]        hop_mem  [ROUTES];
   logic [31:0]        cost_mem [ROUTES];
   logic [7:0]         ifc_mem  [ROUTES];

   entry_type          rd_node_ff, root_ff, entry_ff;
   logic [31:0]        rd_hop_ff, rd_cost_ff;
   logic [7:0]         rd_ifc_ff;
   logic               op_ff;
   logic [31:0]        addr_ff, hop_ff, metric_ff;
   logic [7:0]         ifc_ff;
   logic [LW-1:0]      limit_ff, depth_ff;
   logic [NODE_W-1:0]  node_ff;
   logic               found_ff;
   logic [ROUTE_W-1:0] best_ff;
   logic [NC_W-1:0]    node_count_ff;
   logic [RC_W-1:0]    route_count_ff;
   logic               rsp_valid_ff, acc_ff, fnd_ff, full_ff;
   logic [31:0]        out_hop_ff, out_cost_ff;
   logic [7:0]         out_ifc_ff;

   entry_type          cur, node_wdata, parent_new, set_entry;
   logic [NODE_W-1:0]  child;
   logic               walk_done, node_we;
   logic [LW-1:0]      missing;
   logic [NC_W:0]      need_nodes;
   logic               need_route;
   logic [ROUTE_W-1:0] new_slot, route_wa, route_ra;
   logic               route_we;

   // Entry of the node under the walk and its child on the address bit
   always_comb begin
      cur        = (node_ff == '0) ? root_ff : rd_node_ff;
      child      = addr_ff[31] ? cur.right : cur.left;
      walk_done  = (depth_ff == limit_ff) || (child == '0);
      missing    = limit_ff - depth_ff;
      need_nodes = {1'b0, node_count_ff} + (NC_W + 1)'(missing);
      need_route = (depth_ff != limit_ff) || !entry_ff.has_route;
      new_slot   = route_count_ff[ROUTE_W-1:0];
      parent_new = entry_ff;
      if (addr_ff[31]) parent_new.right = node_count_ff[NODE_W-1:0];
      else             parent_new.left  = node_count_ff[NODE_W-1:0];
      set_entry           = entry_ff;
      set_entry.has_route = 1'b1;
      set_entry.route     = new_slot;
      node_we    = cmd.alloc || cmd.set_route;
      node_wdata = cmd.alloc ? parent_new : set_entry;
      route_we   = cmd.set_route || cmd.replace;
      route_wa   = cmd.set_route ? new_slot : entry_ff.route;
      route_ra   = op_ff ? best_ff : entry_ff.route;
   end

   // Status to the controller
   always_comb begin
      status.is_lookup  = op_ff;
      status.walk_done  = walk_done;
      status.found_now  = found_ff || cur.has_route;
      status.full       = (need_nodes > (NC_W + 1)'(NODES)) ||
                          (need_route && (route_count_ff >= RC_W'(ROUTES)));
      status.at_end     = (depth_ff == limit_ff);
      status.has_route  = entry_ff.has_route;
      status.alloc_last = ((depth_ff + 6'd1) == limit_ff);
      status.cheaper    = metric_ff < rd_cost_ff;
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // Node memory: read the child every cycle, write a parent or end node
   always_ff @(posedge clock) begin
      rd_node_ff <= node_mem[child];
      if (node_we && (node_ff != '0)) node_mem[node_ff] <= node_wdata;
   end

   // Route memories: one read port, one write port
   always_ff @(posedge clock) begin
      rd_hop_ff  <= hop_mem[route_ra];
      rd_cost_ff <= cost_mem[route_ra];
      rd_ifc_ff  <= ifc_mem[route_ra];
      if (route_we) begin
         hop_mem[route_wa]  <= hop_ff;
         cost_mem[route_wa] <= metric_ff;
         ifc_mem[route_wa]  <= ifc_ff;
      end
   end

   // Root node, pool counters and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff        <= '0;
         node_count_ff  <= NC_W'(1);
         route_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (node_we && (node_ff == '0)) root_ff <= node_wdata;
         if (cmd.alloc) node_count_ff <= node_count_ff + NC_W'(1);
         if (cmd.set_route) route_count_ff <= route_count_ff + RC_W'(1);
         if (cmd.load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Item registers and walk position
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff     <= in_operation;
         addr_ff   <= in_address;
         hop_ff    <= in_next_hop;
         metric_ff <= in_route_metric;
         ifc_ff    <= in_interface_index;
         if (in_operation || (in_prefix_length > brt_pkg::MAX_DEPTH))
            limit_ff <= brt_pkg::MAX_DEPTH;
         else
            limit_ff <= in_prefix_length;
         node_ff   <= '0;
         depth_ff  <= '0;
         found_ff  <= 1'b0;
         best_ff   <= '0;
      end else if (cmd.walk) begin
         if (cur.has_route) begin
            found_ff <= 1'b1;
            best_ff  <= cur.route;
         end
         if (walk_done) begin
            entry_ff <= cur;
         end else begin
            node_ff  <= child;
            depth_ff <= depth_ff + 6'd1;
            addr_ff  <= {addr_ff[30:0], 1'b0};
         end
      end else if (cmd.alloc) begin
         entry_ff <= '0;
         node_ff  <= node_count_ff[NODE_W-1:0];
         depth_ff <= depth_ff + 6'd1;
         addr_ff  <= {addr_ff[30:0], 1'b0};
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         acc_ff      <= 1'b0;
         fnd_ff      <= 1'b0;
         full_ff     <= 1'b0;
         out_hop_ff  <= '0;
         out_cost_ff <= '0;
         out_ifc_ff  <= '0;
         case (cmd.kind)
            brt_pkg::RESP_FULL:   full_ff <= 1'b1;
            brt_pkg::RESP_ACCEPT: acc_ff  <= 1'b1;
            brt_pkg::RESP_LOOKUP: begin
               if (found_ff) begin
                  fnd_ff      <= 1'b1;
                  out_hop_ff  <= rd_hop_ff;
                  out_cost_ff <= rd_cost_ff;
                  out_ifc_ff  <= rd_ifc_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = acc_ff;
   assign rsp_found         = fnd_ff;
   assign rsp_out_next_hop  = out_hop_ff;
   assign rsp_out_metric    = out_cost_ff;
   assign rsp_out_interface = out_ifc_ff;
   assign rsp_table_full    = full_ff;

   // Pools never overrun and the walk never passes its limit
   a_node_pool: assert property (@(posedge clock) disable iff (reset)
      node_count_ff <= NC_W'(NODES)) else $error("node pool overrun");
   a_route_pool: assert property (@(posedge clock) disable iff (reset)
      route_count_ff <= RC_W'(ROUTES)) else $error("route pool overrun");
   a_depth: assert property (@(posedge clock) disable iff (reset)
      cmd.walk |-> depth_ff <= limit_ff) else $error("walk past limit");
   a_alloc_count: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc |=> node_count_ff == $past(node_count_ff) + NC_W'(1))
      else $error("allocation miscounted");

endmodule

// File: design/binary_trie_route_table.sv
// Binary trie route table (IPv4 longest prefix match), top level.
// Depends on brt_pkg, brt_if, brt_ctrl and brt_dp.
//
// Usage: req_chan carries one item per operation: an insert (operation 0) of
// a route given by address, prefix_length, next_hop, route_metric and
// interface_index, or a lookup (operation 1) of address. rsp_chan returns one
// item per request: accepted or table_full for an insert, found and the best
// route for a lookup. Both use valid/ready; an item moves when both are high.
// One item is worked at a time, one trie level per cycle (one node memory
// read each). A lookup walks down the trie along the address and, if a route
// matched, reads it from the route memories before its response is loaded.
// An insert walks, checks both pools and is refused if one lacks room; else
// it allocates any missing nodes and writes the route, or, if a route is
// already there, compares metrics and replaces it only if the new one is lower.
// req_chan.ready rises again the cycle after the response is loaded.
// Reset leaves only the root node and empty pools; no clearing pass is run.
// If rsp_chan stalls, the finished response is held in the output register
// and the next item is accepted, but its response waits for the slot to free.
module binary_trie_route_table #(
   parameter int ROUTES = brt_pkg::ROUTES_DEF,
   parameter int NODES  = brt_pkg::NODES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   brt_req_if.sink   req_chan,
   brt_rsp_if.source rsp_chan
);

   brt_pkg::ctrl_cmd_type  cmd;
   brt_pkg::dp_status_type status;
   logic                   idle;

   // Accept a new item only between operations
   assign req_chan.ready = idle;

   brt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .idle      (idle),
      .status    (status),
      .cmd       (cmd)
   );

   brt_dp #(
      .ROUTES (ROUTES),
      .NODES  (NODES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .in_operation       (req_chan.operation),
      .in_address         (req_chan.address),
      .in_prefix_length   (req_chan.prefix_length),
      .in_next_hop        (req_chan.next_hop),
      .in_route_metric    (req_chan.route_metric),
      .in_interface_index (req_chan.interface_index),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_accepted       (rsp_chan.accepted),
      .rsp_found          (rsp_chan.found),
      .rsp_out_next_hop   (rsp_chan.out_next_hop),
      .rsp_out_metric     (rsp_chan.out_metric),
      .rsp_out_interface  (rsp_chan.out_interface),
      .rsp_table_full     (rsp_chan.table_full)
   );

endmodule

// File: tb/binary_trie_route_table_checker.sv
// Scoreboard for the binary trie route table: watches both channels, keeps its
// own trie and route pools, predicts each response and compares field by field.
// Depends on brt_pkg and brt_if.
`timescale 1ns / 1ps
module binary_trie_route_table_checker #(
   parameter int ROUTES = brt_pkg::ROUTES_DEF,
   parameter int NODES  = brt_pkg::NODES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   brt_req_if.monitor req_mon,
   brt_rsp_if.monitor rsp_mon,
   output int         fail_count,
   output int         pending_count
);
   typedef struct packed {
      logic        accepted;
      logic        found;
      logic [31:0] out_next_hop;
      logic [31:0] out_metric;
      logic [7:0]  out_interface;
      logic        table_full;
   } route_answer_type;

   int unsigned      left_child [NODES];
   int unsigned      right_child[NODES];
   bit               node_has_route[NODES];
   int unsigned      node_route[NODES];
   int unsigned      nodes_used;
   logic [31:0]      hop_pool [ROUTES];
   logic [31:0]      cost_pool[ROUTES];
   logic [7:0]       ifc_pool [ROUTES];
   int unsigned      routes_used;
   route_answer_type answer_queue[$];

   function automatic int unsigned child_at(int unsigned n, logic b);
      return b ? right_child[n] : left_child[n];
   endfunction

   // Apply one request to the shadow trie and return the response it causes.
   function automatic route_answer_type route_table_step(logic op, logic [31:0] addr,
         logic [5:0] plen, logic [31:0] hop, logic [31:0] cost, logic [7:0] ifc);
      route_answer_type r;
      int unsigned n, d, len, missing, slot, fresh;
      bit need_route, hit;
      int unsigned best;
      r = '0;
      n = 0;
      if (op == brt_pkg::OP_INSERT) begin
         len = (plen > 32) ? 32 : plen;
         d = 0;
         while (d < len && child_at(n, addr[31-d]) != 0) begin
            n = child_at(n, addr[31-d]);
            d++;
         end
         missing = len - d;
         need_route = (missing > 0) || !node_has_route[n];
         if (nodes_used + missing > NODES || (need_route && routes_used >= ROUTES)) begin
            r.table_full = 1'b1;
            return r;
         end
         // Allocate the missing path.
         while (d < len) begin
            fresh = nodes_used++;
            left_child[fresh] = 0;
            right_child[fresh] = 0;
            node_has_route[fresh] = 0;
            node_route[fresh] = 0;
            if (addr[31-d]) right_child[n] = fresh;
            else left_child[n] = fresh;
            n = fresh;
            d++;
         end
         if (!node_has_route[n]) begin
            slot = routes_used++;
            node_has_route[n] = 1;
            node_route[n] = slot;
         end else begin
            slot = node_route[n];
            if (!(cost < cost_pool[slot])) return r;
         end
         hop_pool[slot] = hop;
         cost_pool[slot] = cost;
         ifc_pool[slot] = ifc;
         r.accepted = 1'b1;
      end else begin
         hit = node_has_route[0];
         best = node_route[0];
         for (int i = 31; i >= 0; i--) begin
            if (child_at(n, addr[i]) == 0) break;
            n = child_at(n, addr[i]);
            if (node_has_route[n]) begin
               hit = 1;
               best = node_route[n];
            end
         end
         if (hit) begin
            r.found = 1'b1;
            r.out_next_hop = hop_pool[best];
            r.out_metric = cost_pool[best];
            r.out_interface = ifc_pool[best];
         end
      end
      return r;
   endfunction

   assign pending_count = answer_queue.size();

   // Predict on each accepted request, compare on each accepted response.
   always @(posedge clock) begin
      route_answer_type want;
      if (reset) begin
         nodes_used <= 1;
         routes_used <= 0;
         left_child[0] <= 0;
         right_child[0] <= 0;
         node_has_route[0] <= 0;
         node_route[0] <= 0;
         answer_queue.delete();
         fail_count <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (answer_queue.size() == 0) begin
               $error("response with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               want = answer_queue.pop_front();
               if (rsp_mon.accepted !== want.accepted ||
                   rsp_mon.found !== want.found ||
                   rsp_mon.out_next_hop !== want.out_next_hop ||
                   rsp_mon.out_metric !== want.out_metric ||
                   rsp_mon.out_interface !== want.out_interface ||
                   rsp_mon.table_full !== want.table_full)
                  fail_count <= fail_count + 1;
               if (rsp_mon.accepted !== want.accepted)
                  $error("accepted: expected %0h, got %0h", want.accepted, rsp_mon.accepted);
               if (rsp_mon.found !== want.found)
                  $error("found: expected %0h, got %0h", want.found, rsp_mon.found);
               if (rsp_mon.out_next_hop !== want.out_next_hop)
                  $error("out_next_hop: expected %0h, got %0h",
                         want.out_next_hop, rsp_mon.out_next_hop);
               if (rsp_mon.out_metric !== want.out_metric)
                  $error("out_metric: expected %0h, got %0h",
                         want.out_metric, rsp_mon.out_metric);
               if (rsp_mon.out_interface !== want.out_interface)
                  $error("out_interface: expected %0h, got %0h",
                         want.out_interface, rsp_mon.out_interface);
               if (rsp_mon.table_full !== want.table_full)
                  $error("table_full: expected %0h, got %0h",
                         want.table_full, rsp_mon.table_full);
            end
         end
         if (req_mon.valid && req_mon.ready)
            answer_queue.push_back(route_table_step(req_mon.operation, req_mon.address,
               req_mon.prefix_length, req_mon.next_hop, req_mon.route_metric,
               req_mon.interface_index));
      end
   end
endmodule

// File: tb/binary_trie_route_table_test.sv
// Top of the route table testbench: clock, reset, request stimulus, response
// back-pressure and the verdict. Depends on brt_pkg, brt_if, the block and the checker.
`timescale 1ns / 1ps
module binary_trie_route_table_test;
   localparam int  RAND_ITEMS  = 880;
   localparam int  CYCLE_LIMIT = 400000;

   logic clock = 0;
   logic reset = 1;
   int   fail_count, pending_count;
   int   cycle_count = 0;
   bit   quiet_tail = 0;
   bit   hold_off = 0;
   logic [31:0] prefix_pool[$];

   brt_req_if req_chan();
   brt_rsp_if rsp_chan();

   binary_trie_route_table u_dut (.clock, .reset, .req_chan(req_chan.sink),
                                  .rsp_chan(rsp_chan.source));

   binary_trie_route_table_checker u_checker (.clock, .reset, .req_mon(req_chan.monitor),
      .rsp_mon(rsp_chan.monitor), .fail_count, .pending_count);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // Count cycles and stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("binary_trie_route_table_test: done, errors");
         $finish;
      end
   end

   // Drive response ready: random stall bursts, a long hold when asked.
   initial begin
      rsp_chan.ready = 0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_chan.ready <= 0;
            repeat (300) @(negedge clock);
            hold_off = 0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end
         rsp_chan.ready <= 1;
      end
   end

   // Offer one request at the falling edge and hold it until taken.
   task automatic send_request(logic op, logic [31:0] addr, logic [5:0] plen,
                               logic [31:0] hop, logic [31:0] cost, logic [7:0] ifc);
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_chan.valid <= 1;
      req_chan.operation <= op;
      req_chan.address <= addr;
      req_chan.prefix_length <= plen;
      req_chan.next_hop <= hop;
      req_chan.route_metric <= cost;
      req_chan.interface_index <= ifc;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic insert_route(logic [31:0] addr, logic [5:0] plen, logic [31:0] cost);
      send_request(brt_pkg::OP_INSERT, addr, plen, $urandom, cost,
                   8'($urandom_range(0, 255)));
   endtask

   task automatic lookup_address(logic [31:0] addr);
      send_request(brt_pkg::OP_LOOKUP, addr, 6'($urandom_range(0, 63)), $urandom, $urandom,
                   8'($urandom_range(0, 255)));
   endtask

   task automatic wait_drained;
      req_chan.valid <= 0;
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      logic [31:0] a;
      int sel;
      req_chan.valid = 0;
      req_chan.operation = brt_pkg::OP_INSERT;
      req_chan.address = 0;
      req_chan.prefix_length = 0;
      req_chan.next_hop = 0;
      req_chan.route_metric = 0;
      req_chan.interface_index = 0;
      repeat (2) @(negedge clock);
      reset = 0;

      // Directed: empty lookup, default route, extremes, metric ties, long prefix.
      lookup_address(32'h0A000001);
      insert_route(32'hFFFFFFFF, 6'd0, 32'd100);
      lookup_address(32'h12345678);
      insert_route(32'h0, 6'd0, 32'd100);
      insert_route(32'h0, 6'd0, 32'd99);
      insert_route(32'h0, 6'd0, 32'hFFFFFFFF);
      insert_route(32'hFFFFFFFF, 6'd32, 32'hFFFFFFFF);
      insert_route(32'hFFFFFFFF, 6'd63, 32'h0);
      lookup_address(32'hFFFFFFFF);
      lookup_address(32'hFFFFFFFE);
      insert_route(32'h0A0000FF, 6'd8, 32'd5);
      insert_route(32'h0A000000, 6'd24, 32'd7);
      insert_route(32'h00000000, 6'd32, 32'd0);
      insert_route(32'h0A000000, 6'd24, 32'd7);
      lookup_address(32'h0A000001);
      lookup_address(32'h0A010101);
      lookup_address(32'h00000000);
      send_request(brt_pkg::OP_INSERT, 32'hC0A80000, 6'd16, 32'hFFFFFFFF, 32'd3, 8'hFF);
      send_request(brt_pkg::OP_INSERT, 32'h80000000, 6'd1, 32'h0, 32'd0, 8'h00);
      lookup_address(32'hC0A80101);
      lookup_address(32'h7FFFFFFF);
      wait_drained();

      // Long receiver hold-off while requests keep coming.
      hold_off = 1;
      for (int i = 0; i < 6; i++) lookup_address($urandom);
      wait_drained();

      // Random: half lookups, mostly near known prefixes, half inserts, mostly with lengths up to 24.
      for (int i = 0; i < RAND_ITEMS; i++) begin
         if (i == RAND_ITEMS - 100) quiet_tail = 1;
         sel = $urandom_range(0, 9);
         if (prefix_pool.size() > 0 && sel < 4)
            a = prefix_pool[$urandom_range(0, prefix_pool.size() - 1)] ^
                ($urandom >> $urandom_range(4, 31));
         else
            a = $urandom;
         if (sel < 5) lookup_address(a);
         else begin
            if (prefix_pool.size() < 64) prefix_pool.push_back(a);
            insert_route(a, ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                            : 6'($urandom_range(0, 24)), $urandom_range(0, 3) == 0 ?
                            $urandom_range(0, 8) : $urandom);
         end
      end
      wait_drained();
      repeat (50) @(negedge clock);
      if (fail_count == 0)
         $display("binary_trie_route_table_test: done, clean");
      else
         $display("binary_trie_route_table_test: done, errors");
      $finish;
   end
endmodule
